// File: rtl/websocket_frame_receiver_macros.svh
// ----------------------------------------------------------------------------
// WebSocket frame receiver assertion macros
// Shared property wrappers, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef WEBSOCKET_FRAME_RECEIVER_MACROS_SVH
`define WEBSOCKET_FRAME_RECEIVER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WSFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WSFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wsfr_pkg.sv
// ----------------------------------------------------------------------------
// WebSocket frame receiver package
// Widths, result kinds, register map and the result record.
// ----------------------------------------------------------------------------
package wsfr_pkg;

  // Width of the kept frame length and of the byte counter (16 to 64).
  localparam int LEN_WIDTH = 64;

  localparam int BYTE_W = 8;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  // Register index decoded from the word address bit.
  localparam logic REG_EXT_BYTES = 1'b0;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_EMPTY = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_ERROR = 2'd3
  } wsfr_kind_t;

  // One result word as produced by the parser.
  typedef struct packed {
    logic              valid;
    wsfr_kind_t        kind;
    logic [BYTE_W-1:0] data_byte;
    logic              is_binary;
    logic              last;
  } wsfr_result_t;

endpackage

// File: rtl/wsfr_in_reg.sv
// ----------------------------------------------------------------------------
// WebSocket frame receiver input stage
// Skid buffer: a main register feeding the parser and a spare register, so
// that the ready toward the link is a plain flop.
// ----------------------------------------------------------------------------
module wsfr_in_reg
  import wsfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [BYTE_W-1:0] in_tdata,
  output logic              byte_valid,
  output logic [BYTE_W-1:0] byte_data,
  input  logic              byte_take
);

  logic              main_valid_r;
  logic [BYTE_W-1:0] main_byte_r;
  logic              skid_valid_r;
  logic [BYTE_W-1:0] skid_byte_r;
  logic              accept;

  assign in_tready  = !skid_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign byte_valid = main_valid_r;
  assign byte_data  = main_byte_r;

  // Main register refills from the spare word first, then from the link.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (byte_take || !main_valid_r) begin
      if (skid_valid_r) begin
        main_valid_r <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        main_valid_r <= accept;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload moves without reset.
  always_ff @(posedge clk) begin
    if (byte_take || !main_valid_r) begin
      if (skid_valid_r) begin
        main_byte_r <= skid_byte_r;
      end else if (accept) begin
        main_byte_r <= in_tdata;
      end
    end else if (accept) begin
      skid_byte_r <= in_tdata;
    end
  end

endmodule

// File: rtl/wsfr_parser.sv
// ----------------------------------------------------------------------------
// WebSocket frame receiver parser
// Frame state and the single-pass decode of one byte into at most one
// result word.
// ----------------------------------------------------------------------------
`include "websocket_frame_receiver_macros.svh"

module wsfr_parser
  import wsfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [BYTE_W-1:0] ext_bytes,
  input  logic              byte_valid,
  input  logic [BYTE_W-1:0] byte_data,
  output logic              byte_take,
  input  logic              slot_free,
  output wsfr_result_t      res
);

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_LEN16   = 3'd2,
    PH_LEN64   = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5
  } phase_t;

  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] LAST_LEN16 = 4'd1;
  localparam logic [3:0] LAST_LEN64 = 4'd7;
  localparam logic [3:0] LAST_KEY   = 4'd3;
  localparam logic [3:0] OP_BINARY  = 4'd2;
  localparam logic [3:0] OP_CLOSE   = 4'd8;

  phase_t               phase_r, phase_nxt;
  logic                 closed_r, closed_nxt;
  logic [BYTE_W-1:0]    hdr_high_r, hdr_high_nxt;
  logic                 fin_r, fin_nxt;
  logic [3:0]           opcode_r, opcode_nxt;
  logic                 mask_r, mask_nxt;
  logic [LEN_WIDTH-1:0] flen_r, flen_nxt;
  logic [31:0]          key_r, key_nxt;
  logic [LEN_WIDTH-1:0] cnt_r, cnt_nxt;

  logic                 len_known;
  logic                 arm;
  logic [LEN_WIDTH-1:0] arm_len;
  logic [LEN_WIDTH-1:0] ext_wide;
  logic                 do_finish;
  logic [LEN_WIDTH-1:0] shifted_len;
  logic [LEN_WIDTH:0]   idx_inc;
  logic                 is_last;
  logic [BYTE_W-1:0]    key_byte;
  logic                 deliver;

  assign byte_take   = byte_valid && slot_free;
  assign ext_wide    = LEN_WIDTH'(ext_bytes);
  assign shifted_len = {flen_r[LEN_WIDTH-BYTE_W-1:0], byte_data};
  assign idx_inc     = {1'b0, cnt_r} + (LEN_WIDTH+1)'(1);
  assign is_last     = idx_inc >= {1'b0, flen_r};
  assign deliver     = !opcode_r[3] && fin_r && (cnt_r >= ext_wide);

  // Key byte for this payload position; the first key byte received is the
  // most significant one.
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  // Decode of one byte.
  always_comb begin
    phase_nxt    = phase_r;
    closed_nxt   = closed_r;
    hdr_high_nxt = hdr_high_r;
    fin_nxt      = fin_r;
    opcode_nxt   = opcode_r;
    mask_nxt     = mask_r;
    flen_nxt     = flen_r;
    key_nxt      = key_r;
    cnt_nxt      = cnt_r;
    len_known    = 1'b0;
    arm          = 1'b0;
    arm_len      = flen_r;
    do_finish    = 1'b0;
    res          = '0;

    if (byte_take && !closed_r) begin
      unique case (phase_r)
        PH_HDR0: begin
          hdr_high_nxt = byte_data;
          phase_nxt    = PH_HDR1;
        end
        PH_HDR1: begin
          fin_nxt    = hdr_high_r[7];
          opcode_nxt = hdr_high_r[3:0];
          mask_nxt   = byte_data[7];
          flen_nxt   = '0;
          cnt_nxt    = '0;
          if (byte_data[6:0] == LEN7_EXT16) begin
            phase_nxt = PH_LEN16;
          end else if (byte_data[6:0] == LEN7_EXT64) begin
            phase_nxt = PH_LEN64;
          end else begin
            len_known = 1'b1;
            flen_nxt  = LEN_WIDTH'(byte_data[6:0]);
            arm_len   = LEN_WIDTH'(byte_data[6:0]);
          end
        end
        PH_LEN16, PH_LEN64: begin
          flen_nxt = shifted_len;
          arm_len  = shifted_len;
          cnt_nxt  = cnt_r + LEN_WIDTH'(1);
          if (cnt_r[3:0] == ((phase_r == PH_LEN16) ? LAST_LEN16 : LAST_LEN64)) begin
            len_known = 1'b1;
          end
        end
        PH_KEY: begin
          key_nxt = {key_r[23:0], byte_data};
          cnt_nxt = cnt_r + LEN_WIDTH'(1);
          if (cnt_r[3:0] == LAST_KEY) begin
            arm = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          cnt_nxt = idx_inc[LEN_WIDTH-1:0];
          if (deliver) begin
            if (is_last) begin
              phase_nxt = PH_HDR0;
              cnt_nxt   = '0;
            end
            res.valid     = 1'b1;
            res.kind      = KIND_DATA;
            res.data_byte = mask_r ? (byte_data ^ key_byte) : byte_data;
            res.is_binary = (opcode_r == OP_BINARY);
            res.last      = is_last;
          end else if (is_last) begin
            do_finish = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_HDR0;
          cnt_nxt   = '0;
        end
      endcase

      // Length known: a masked frame goes on to the key.
      if (len_known) begin
        cnt_nxt = '0;
        if (mask_nxt) begin
          phase_nxt = PH_KEY;
        end else begin
          arm = 1'b1;
        end
      end

      // Start the payload, with the length raised to the extension count, or finish a frame that has no bytes.
      if (arm) begin
        cnt_nxt  = '0;
        flen_nxt = (arm_len < ext_wide) ? ext_wide : arm_len;
        if ((arm_len == '0) && (ext_bytes == '0)) begin
          do_finish = 1'b1;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end

      // Frame end without a delivered byte.
      if (do_finish) begin
        phase_nxt = PH_HDR0;
        cnt_nxt   = '0;
        res.valid = 1'b1;
        res.last  = 1'b1;
        if (opcode_nxt[3]) begin
          closed_nxt = 1'b1;
          res.kind   = (opcode_nxt == OP_CLOSE) ? KIND_CLOSE : KIND_ERROR;
        end else if (!fin_nxt) begin
          closed_nxt = 1'b1;
          res.kind   = KIND_ERROR;
        end else begin
          res.kind      = KIND_EMPTY;
          res.is_binary = (opcode_nxt == OP_BINARY);
        end
      end
    end
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      closed_r   <= 1'b0;
      hdr_high_r <= '0;
      fin_r      <= 1'b0;
      opcode_r   <= '0;
      mask_r     <= 1'b0;
      flen_r     <= '0;
      key_r      <= '0;
      cnt_r      <= '0;
    end else begin
      phase_r    <= phase_nxt;
      closed_r   <= closed_nxt;
      hdr_high_r <= hdr_high_nxt;
      fin_r      <= fin_nxt;
      opcode_r   <= opcode_nxt;
      mask_r     <= mask_nxt;
      flen_r     <= flen_nxt;
      key_r      <= key_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  // Once closed, the block stays closed until reset.
  `WSFR_ASSERT_NEXT(a_closed_sticky, closed_r, closed_r, "closed flag cleared without reset")
  // Close and error results shut the block down.
  `WSFR_ASSERT_NEXT(a_close_sets_closed,
    res.valid && (res.kind == KIND_CLOSE || res.kind == KIND_ERROR),
    closed_r, "close or error did not set closed")
  // Every result other than a payload byte ends its frame.
  `WSFR_ASSERT_NOW(a_event_last, res.valid && res.kind != KIND_DATA, res.last,
    "frame event without last mark")
  // A frame in its payload always has bytes left.
  `WSFR_ASSERT_NOW(a_payload_left, phase_r == PH_PAYLOAD, cnt_r < flen_r,
    "payload phase with no bytes left")

endmodule

// File: rtl/wsfr_out_reg.sv
// ----------------------------------------------------------------------------
// WebSocket frame receiver output register
// Holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module wsfr_out_reg
  import wsfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  wsfr_result_t      res,
  output logic              slot_free,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [BYTE_W-1:0] out_tdata,
  output logic [2:0]        out_tuser,
  output logic              out_tlast
);

  logic         out_valid_r;
  wsfr_result_t res_r;

  assign slot_free  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = res_r.data_byte;
  assign out_tuser  = {res_r.is_binary, res_r.kind};
  assign out_tlast  = res_r.last;

  // Valid flag follows the parser whenever the slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (slot_free) begin
      out_valid_r <= res.valid;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (slot_free && res.valid) begin
      res_r <= res;
    end
  end

endmodule

// File: rtl/websocket_frame_receiver.sv
// ----------------------------------------------------------------------------
// WebSocket frame receiver
// Deframes a received byte stream: header, extended length, masking key,
// unmasked payload bytes, and frame events.
//
//   Channel  Direction  Carries
//   in_      sink       one received byte per word
//   out_     source     payload byte, empty frame, close or error event
//   cfg_     APB slave  extension_bytes at byte address 0
//
// One byte per clock is accepted and decoded while the result register is not
// stalled; a byte passes through the input register, then the result register.
// The decode is a single pass through the frame state; the 64-bit length
// compare sets the critical path.
// rst_n is synchronous; no memory clearing is needed after reset.
// in_tready drops only when the spare input register holds a word because
// the result register is stalled.
// ----------------------------------------------------------------------------
module websocket_frame_receiver
  import wsfr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [BYTE_W-1:0]     in_tdata,   // [7:0] byte_in
  // Result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [BYTE_W-1:0]     out_tdata,  // [7:0] data_byte
  output logic [2:0]            out_tuser,  // [1:0] kind, [2] is_binary
  output logic                  out_tlast,
  // Configuration
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic              ext_sel;
  logic [BYTE_W-1:0] ext_val_r;
  logic              cfg_wr;
  logic              byte_valid;
  logic [BYTE_W-1:0] byte_data;
  logic              byte_take;
  logic              slot_free;
  wsfr_result_t      res;

  // Configuration register.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign ext_sel    = (cfg_paddr[2] == REG_EXT_BYTES);
  assign cfg_prdata = ext_sel ? CFG_DATA_W'(ext_val_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ext_val_r <= '0;
    end else if (cfg_wr && ext_sel) begin
      ext_val_r <= cfg_pwdata[BYTE_W-1:0];
    end
  end

  wsfr_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take)
  );

  wsfr_parser u_parser (
    .clk        (clk),
    .rst_n      (rst_n),
    .ext_bytes  (ext_val_r),
    .byte_valid (byte_valid),
    .byte_data  (byte_data),
    .byte_take  (byte_take),
    .slot_free  (slot_free),
    .res        (res)
  );

  wsfr_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .res        (res),
    .slot_free  (slot_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
